@@ rtl/fptw_pkg.sv @@
// fptw_pkg: shared types and constants of the four-level page-table engine
// no dependencies; imported by every module of the block but fptw_ram

package fptw_pkg;

  localparam int ENTRIES_PER_TABLE = 512;
  localparam int IDX_W = 9;

  localparam int BIT_PRESENT = 0;
  localparam int BIT_USER = 2;
  localparam int BIT_HUGE = 7;

  typedef enum logic [1:0] {
    MODE_TRANSLATE = 2'd0,
    MODE_MAP       = 2'd1,
    MODE_UNMAP     = 2'd2,
    MODE_RAW       = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ABSENT    = 2'd1,
    ST_EXHAUSTED = 2'd2,
    ST_OUTSIDE   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_ROOT_FRAME  = 2'd0,
    REG_ALLOC_BASE  = 2'd1,
    REG_ALLOC_LIMIT = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    WS_INIT,
    WS_IDLE,
    WS_READ,
    WS_EVAL,
    WS_CLEAR,
    WS_LINK,
    WS_LEAF,
    WS_DONE
  } walk_state_t;

  typedef struct packed {
    mode_t        mode;
    logic [47:0]  virt_addr;
    logic [51:0]  phys_addr;
    logic [11:0]  entry_flags;
    logic [14:0]  entry_index;
    logic [63:0]  entry_value;
    logic         raw_ok;
  } item_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  index;
    logic [6:0]  data;
  } cfg_wr_t;

  typedef struct packed {
    logic pop;
    logic busy;
  } back_ctl_t;

  function automatic logic [IDX_W-1:0] lvl_index(input logic [47:0] va,
                                                 input logic [1:0] lvl);
    logic [IDX_W-1:0] r;
    case (lvl)
      2'd3:    r = va[47:39];
      2'd2:    r = va[38:30];
      2'd1:    r = va[29:21];
      default: r = va[20:12];
    endcase
    return r;
  endfunction

endpackage

@@ rtl/fptw_ram.sv @@
// fptw_ram: generic single-clock ram with registered read
// no dependencies

module fptw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/fptw_front.sv @@
// fptw_front: accepts input items, classifies raw writes, two-entry queue
// depends on fptw_pkg

module fptw_front import fptw_pkg::*; #(
  parameter int STORE_FRAMES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [47:0] virt_addr,
  input  logic [51:0] phys_addr,
  input  logic [11:0] entry_flags,
  input  logic [14:0] entry_index,
  input  logic [63:0] entry_value,
  input  back_ctl_t   ctl,
  output logic        head_valid,
  output item_t       head
);

  localparam int DEPTH = STORE_FRAMES * ENTRIES_PER_TABLE;

  item_t      q [2];
  logic       wp, rp;
  logic [1:0] count;
  logic       push;
  item_t      incoming;

  assign in_ready   = (count != 2'd2) && !ctl.busy;
  assign push       = in_valid && in_ready;
  assign head_valid = (count != 2'd0);
  assign head       = q[rp];

  always_comb begin
    incoming.mode        = mode_t'(mode);
    incoming.virt_addr   = virt_addr;
    incoming.phys_addr   = phys_addr;
    incoming.entry_flags = entry_flags;
    incoming.entry_index = entry_index;
    incoming.entry_value = entry_value;
    incoming.raw_ok      = (32'(entry_index) < DEPTH);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (ctl.pop) rp <= ~rp;
      count <= count + 2'(push) - 2'(ctl.pop);
    end
  end

endmodule

@@ rtl/fptw_walker.sv @@
// fptw_walker: table store, walk sequencer, frame allocator, result register
// depends on fptw_pkg and fptw_ram

module fptw_walker import fptw_pkg::*; #(
  parameter int STORE_FRAMES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_wr_t     cfg,
  input  logic        head_valid,
  input  item_t       head,
  output back_ctl_t   ctl,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [51:0] result_addr,
  output logic [1:0]  status
);

  localparam int DEPTH = STORE_FRAMES * ENTRIES_PER_TABLE;
  localparam int FW = $clog2(STORE_FRAMES);
  localparam int AW = FW + IDX_W;

  walk_state_t      state, state_next;
  logic [1:0]       lvl, lvl_next;
  logic [FW-1:0]    frame, frame_next;
  logic [FW-1:0]    new_frame, new_frame_next;
  logic [AW-1:0]    cnt, cnt_next;
  logic [6:0]       next_free, next_free_next;
  logic [5:0]       root_frame;
  logic [6:0]       alloc_limit;
  logic [51:0]      res_addr, res_addr_next;
  status_t          res_status, res_status_next;

  logic             we;
  logic [AW-1:0]    addr;
  logic [63:0]      wdata, rdata;
  logic [39:0]      ent_frame;
  logic             ent_outside, alloc_bad, slot_free;

  fptw_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (addr),
    .wdata (wdata),
    .raddr (addr),
    .rdata (rdata)
  );

  assign ent_frame   = rdata[51:12];
  assign ent_outside = (ent_frame >= 40'(STORE_FRAMES));
  assign alloc_bad   = (next_free >= alloc_limit) || (32'(next_free) >= STORE_FRAMES);
  assign slot_free   = !out_valid || out_ready;

  always_comb begin
    state_next      = state;
    lvl_next        = lvl;
    frame_next      = frame;
    new_frame_next  = new_frame;
    cnt_next        = cnt;
    next_free_next  = next_free;
    res_addr_next   = res_addr;
    res_status_next = res_status;
    we              = 1'b0;
    addr            = {frame, lvl_index(head.virt_addr, lvl)};
    wdata           = '0;
    ctl.pop         = 1'b0;
    ctl.busy        = (state == WS_INIT);

    unique case (state)
      WS_INIT: begin
        we       = 1'b1;
        addr     = cnt;
        cnt_next = cnt + 1'b1;
        if (cnt == AW'(DEPTH - 1)) state_next = WS_IDLE;
      end
      WS_IDLE: begin
        if (head_valid) begin
          res_addr_next   = '0;
          res_status_next = ST_OK;
          frame_next      = FW'(root_frame);
          lvl_next        = 2'd3;
          if (head.mode == MODE_RAW) begin
            addr       = AW'(head.entry_index);
            wdata      = head.entry_value;
            we         = head.raw_ok;
            if (!head.raw_ok) res_status_next = ST_OUTSIDE;
            state_next = WS_DONE;
          end else if (32'(root_frame) >= STORE_FRAMES) begin
            res_status_next = ST_OUTSIDE;
            state_next      = WS_DONE;
          end else begin
            state_next = WS_READ;
          end
        end
      end
      WS_READ: begin
        state_next = WS_EVAL;
      end
      WS_EVAL: begin
        if (head.mode == MODE_TRANSLATE) begin
          if (!rdata[BIT_PRESENT]) begin
            res_status_next = ST_ABSENT;
            state_next      = WS_DONE;
          end else if (lvl == 2'd1 && rdata[BIT_HUGE]) begin
            res_addr_next = {rdata[51:21], head.virt_addr[20:0]};
            state_next    = WS_DONE;
          end else if (lvl == 2'd0) begin
            res_addr_next = {rdata[51:12], head.virt_addr[11:0]};
            state_next    = WS_DONE;
          end else if (ent_outside) begin
            res_status_next = ST_OUTSIDE;
            state_next      = WS_DONE;
          end else begin
            frame_next = FW'(ent_frame);
            lvl_next   = lvl - 1'b1;
            state_next = WS_READ;
          end
        end else if (rdata[BIT_PRESENT]) begin
          if (ent_outside) begin
            res_status_next = ST_OUTSIDE;
            state_next      = WS_DONE;
          end else begin
            frame_next = FW'(ent_frame);
            lvl_next   = lvl - 1'b1;
            state_next = (lvl == 2'd1) ? WS_LEAF : WS_READ;
          end
        end else if (head.mode == MODE_UNMAP) begin
          res_status_next = ST_ABSENT;
          state_next      = WS_DONE;
        end else if (alloc_bad) begin
          res_status_next = ST_EXHAUSTED;
          state_next      = WS_DONE;
        end else begin
          new_frame_next = FW'(next_free);
          next_free_next = next_free + 1'b1;
          cnt_next       = '0;
          state_next     = WS_CLEAR;
        end
      end
      WS_CLEAR: begin
        // new table is zeroed before its parent entry points at it
        we       = 1'b1;
        addr     = {new_frame, cnt[IDX_W-1:0]};
        cnt_next = cnt + 1'b1;
        if (cnt[IDX_W-1:0] == '1) state_next = WS_LINK;
      end
      WS_LINK: begin
        we         = 1'b1;
        wdata      = {12'd0, 40'(new_frame), 9'd0, head.entry_flags[BIT_USER], 2'b11};
        frame_next = new_frame;
        lvl_next   = lvl - 1'b1;
        state_next = (lvl == 2'd1) ? WS_LEAF : WS_READ;
      end
      WS_LEAF: begin
        we = 1'b1;
        if (head.mode == MODE_MAP) begin
          wdata = {12'd0, head.phys_addr[51:12], head.entry_flags | 12'h001};
        end
        state_next = WS_DONE;
      end
      WS_DONE: begin
        if (slot_free) begin
          ctl.pop    = 1'b1;
          state_next = WS_IDLE;
        end
      end
      default: state_next = WS_IDLE;
    endcase

    if (cfg.valid && cfg.index == REG_ALLOC_BASE) begin
      next_free_next = {1'b0, cfg.data[5:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= WS_INIT;
      cnt         <= '0;
      next_free   <= 7'd1;
      root_frame  <= 6'd0;
      alloc_limit <= 7'd64;
      out_valid   <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      next_free <= next_free_next;
      if (cfg.valid) begin
        case (cfg.index)
          REG_ROOT_FRAME:  root_frame  <= cfg.data[5:0];
          REG_ALLOC_LIMIT: alloc_limit <= cfg.data;
          default: ;
        endcase
      end
      if (ctl.pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    lvl        <= lvl_next;
    frame      <= frame_next;
    new_frame  <= new_frame_next;
    res_addr   <= res_addr_next;
    res_status <= res_status_next;
    if (ctl.pop) begin
      result_addr <= (res_status == ST_OK) ? res_addr : 52'd0;
      status      <= res_status;
    end
  end

endmodule

@@ rtl/four_level_page_table_engine.sv @@
// Four-level page-table engine: translate, map, unmap and raw write on an
// internal table store of STORE_FRAMES frames of 512 64-bit entries.
// After reset the store is swept to zero, one entry a cycle; no item is
// transferred in that time (config writes still are). An item is then
// started; a walk reads each table level from the single-port store (read,
// then decode of registered data), and the result is handed to the output
// register. A map zeroes each table it allocates, one entry a cycle, and
// then writes the parent link. One item is walked at a time; a two-entry
// input queue and the output register let either side stall on its own.

module four_level_page_table_engine import fptw_pkg::*; #(
  parameter int STORE_FRAMES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [47:0] virt_addr,
  input  logic [51:0] phys_addr,
  input  logic [11:0] entry_flags,
  input  logic [14:0] entry_index,
  input  logic [63:0] entry_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [51:0] result_addr,
  output logic [1:0]  status
);

  cfg_wr_t   cfg;
  back_ctl_t ctl;
  logic      head_valid;
  item_t     head;

  assign cfg_ready = 1'b1;
  assign cfg.valid = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  fptw_front #(.STORE_FRAMES(STORE_FRAMES)) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mode        (mode),
    .virt_addr   (virt_addr),
    .phys_addr   (phys_addr),
    .entry_flags (entry_flags),
    .entry_index (entry_index),
    .entry_value (entry_value),
    .ctl         (ctl),
    .head_valid  (head_valid),
    .head        (head)
  );

  fptw_walker #(.STORE_FRAMES(STORE_FRAMES)) u_walker (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .head_valid  (head_valid),
    .head        (head),
    .ctl         (ctl),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_addr (result_addr),
    .status      (status)
  );

`ifndef SYNTH
  a_no_transfer_in_sweep: assert property (@(posedge clk) disable iff (rst)
    ctl.busy |-> !(in_valid && in_ready))
    else $error("input transfer during store sweep");

  a_pop_needs_item: assert property (@(posedge clk) disable iff (rst)
    ctl.pop |-> head_valid)
    else $error("queue popped while empty");

  a_fail_addr_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (result_addr == 52'd0))
    else $error("nonzero address with failing status");

  a_result_after_pop: assert property (@(posedge clk) disable iff (rst)
    ctl.pop |=> out_valid)
    else $error("result register not loaded");
`endif

endmodule

@@ test/fptw_checker.sv @@
// fptw_checker: watches the item, config and result channels of the page-table engine,
// keeps its own table store and predicts every result; counts mismatches
// depends on fptw_pkg

module fptw_checker import fptw_pkg::*; #(
  parameter int STORE_FRAMES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [47:0] virt_addr,
  input  logic [51:0] phys_addr,
  input  logic [11:0] entry_flags,
  input  logic [14:0] entry_index,
  input  logic [63:0] entry_value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [51:0] result_addr,
  input  logic [1:0]  status,
  output int          fail_count,
  output int          pending
);

  localparam int WORDS = STORE_FRAMES * ENTRIES_PER_TABLE;
  localparam logic [63:0] FRAME_MASK = 64'h000F_FFFF_FFFF_F000;

  typedef struct packed {
    logic [51:0] addr;
    status_t     st;
  } walk_res_t;

  logic [63:0] pt_mem [WORDS];
  logic [6:0]  root_frm, next_frm, limit_frm;
  walk_res_t   expected_q[$];

  function automatic logic [8:0] idx_of(logic [47:0] va, int lvl);
    return va[12 + 9*lvl +: 9];
  endfunction

  // follow or create one level; frm is replaced by the child frame
  function automatic status_t step_down(inout logic [63:0] frm, input logic [8:0] idx,
                                        input bit make, input logic [63:0] user);
    logic [63:0] a;
    logic [63:0] nf;
    a = frm * ENTRIES_PER_TABLE + idx;
    if (!pt_mem[a][BIT_PRESENT]) begin
      if (!make) return ST_ABSENT;
      nf = 64'(next_frm);
      if (nf >= limit_frm || nf >= STORE_FRAMES) return ST_EXHAUSTED;
      next_frm = next_frm + 7'd1;
      for (int i = 0; i < ENTRIES_PER_TABLE; i++) pt_mem[nf*ENTRIES_PER_TABLE + i] = '0;
      pt_mem[a] = (nf << 12) | 64'h3 | user;
    end
    frm = (pt_mem[a] & FRAME_MASK) >> 12;
    if (frm >= STORE_FRAMES) return ST_OUTSIDE;
    return ST_OK;
  endfunction

  function automatic walk_res_t predict_walk(logic [1:0] md, logic [47:0] va,
                                             logic [51:0] pa, logic [11:0] fl,
                                             logic [14:0] widx, logic [63:0] wval);
    walk_res_t r;
    logic [63:0] frm, e;
    bit make;
    r.addr = '0;
    r.st = ST_OK;
    frm = 64'(root_frm);
    if (md == MODE_RAW) begin
      if (widx >= WORDS) r.st = ST_OUTSIDE;
      else pt_mem[widx] = wval;
    end else if (frm >= STORE_FRAMES) begin
      r.st = ST_OUTSIDE;
    end else if (md == MODE_TRANSLATE) begin
      for (int l = 3; l >= 2 && r.st == ST_OK; l--)
        r.st = step_down(frm, idx_of(va, l), 1'b0, 64'd0);
      if (r.st == ST_OK) begin
        e = pt_mem[frm*ENTRIES_PER_TABLE + idx_of(va, 1)];
        if (!e[BIT_PRESENT]) r.st = ST_ABSENT;
        else if (e[BIT_HUGE]) r.addr = (e[51:0] & 52'hF_FFFF_FFE0_0000) | va[20:0];
        else begin
          frm = (e & FRAME_MASK) >> 12;
          if (frm >= STORE_FRAMES) r.st = ST_OUTSIDE;
          else begin
            e = pt_mem[frm*ENTRIES_PER_TABLE + idx_of(va, 0)];
            if (!e[BIT_PRESENT]) r.st = ST_ABSENT;
            else r.addr = {e[51:12], va[11:0]};
          end
        end
      end
    end else begin
      make = (md == MODE_MAP);
      for (int l = 3; l >= 1 && r.st == ST_OK; l--)
        r.st = step_down(frm, idx_of(va, l), make, {61'd0, fl[BIT_USER], 2'd0});
      if (r.st == ST_OK)
        pt_mem[frm*ENTRIES_PER_TABLE + idx_of(va, 0)] =
          make ? ({12'd0, pa[51:12], 12'd0} | fl | 64'h1) : 64'd0;
    end
    if (r.st != ST_OK) r.addr = '0;
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    walk_res_t want;
    if (rst) begin
      for (int i = 0; i < WORDS; i++) pt_mem[i] = '0;
      root_frm = 7'd0;
      next_frm = 7'd1;
      limit_frm = 7'd64;
      fail_count = 0;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_ROOT_FRAME: root_frm = {1'b0, cfg_data[5:0]};
          REG_ALLOC_BASE: begin
            next_frm = {1'b0, cfg_data[5:0]};
          end
          REG_ALLOC_LIMIT: limit_frm = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_q.push_back(predict_walk(mode, virt_addr, phys_addr, entry_flags,
                                          entry_index, entry_value));
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result with nothing expected: addr=%h status=%0d",
                   $time, result_addr, status);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (result_addr !== want.addr || status !== want.st) begin
            $display("%0t: mismatch expected addr=%h status=%0d actual addr=%h status=%0d",
                     $time, want.addr, want.st, result_addr, status);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

@@ test/tb_four_level_page_table_engine.sv @@
// tb_four_level_page_table_engine: drives items and config writes into the engine
// with random gaps and back-pressure; depends on fptw_pkg and fptw_checker

module tb_four_level_page_table_engine import fptw_pkg::*;;

  logic        clk = 0, rst = 1;
  logic        cfg_valid = 0, cfg_ready;
  logic [1:0]  cfg_index = 0;
  logic [6:0]  cfg_data = 0;
  logic        in_valid = 0, in_ready;
  logic [1:0]  mode = 0;
  logic [47:0] virt_addr = 0;
  logic [51:0] phys_addr = 0;
  logic [11:0] entry_flags = 0;
  logic [14:0] entry_index = 0;
  logic [63:0] entry_value = 0;
  logic        out_valid, out_ready = 0;
  logic [51:0] result_addr;
  logic [1:0]  status;
  int          fail_count, pending;
  int          cycles = 0;
  int          stall_left = 0;
  bit          stall_on = 1;

  // a few mapped addresses reused so translate and unmap hit real paths
  logic [47:0] va_pool[$];

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  four_level_page_table_engine u_top (.*);

  fptw_checker u_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("four_level_page_table_engine test failed");
      $finish;
    end
  end

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver stalls at random, now and then for a long stretch
  always @(posedge clk) begin
    if (!stall_on) begin
      out_ready <= 1;
    end else if (stall_left > 0) begin
      out_ready  <= 0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < 2) begin
      out_ready  <= 0;
      stall_left <= $urandom_range(10, 40);
    end else begin
      out_ready <= ($urandom_range(0, 9) < 7);
    end
  end

  task automatic send_item(logic [1:0] md, logic [47:0] va, logic [51:0] pa,
                           logic [11:0] fl, logic [14:0] widx, logic [63:0] wval);
    int g;
    g = gap_len();
    if (g != 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    mode <= md;
    virt_addr <= va;
    phys_addr <= pa;
    entry_flags <= fl;
    entry_index <= widx;
    entry_value <= wval;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [6:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  function automatic logic [47:0] rand_va();
    logic [47:0] v;
    v = 48'({$urandom, $urandom});
    // keep most indices in a narrow set so paths share tables
    if ($urandom_range(0, 3) != 0) begin
      v[47:39] = 9'($urandom_range(0, 1));
      v[38:30] = 9'($urandom_range(0, 2));
      v[29:21] = 9'($urandom_range(0, 3));
      v[20:12] = 9'($urandom_range(0, 7));
    end
    return v;
  endfunction

  task automatic random_item();
    int          r;
    logic [47:0] va;
    logic [51:0] pa;
    logic [11:0] fl;
    logic [14:0] wi;
    logic [63:0] w;
    r = $urandom_range(0, 99);
    va = (va_pool.size() != 0 && $urandom_range(0, 1)) ?
         va_pool[$urandom_range(0, va_pool.size()-1)] : rand_va();
    va[11:0] = 12'($urandom);
    pa = 52'({$urandom, $urandom});
    fl = 12'($urandom);
    wi = 15'($urandom);
    w = {$urandom, $urandom};
    if (r < 35) begin
      if (va_pool.size() < 32) va_pool.push_back(va);
      send_item(MODE_MAP, va, pa, fl, wi, w);
    end else if (r < 75) begin
      send_item(MODE_TRANSLATE, va, pa, fl, wi, w);
    end else if (r < 88) begin
      send_item(MODE_UNMAP, va, pa, fl, wi, w);
    end else begin
      // raw write: huge PD entries, out-of-store frames, or noise
      case ($urandom_range(0, 2))
        0: w = {12'd0, w[51:21], 21'd0} | 64'h81;
        1: w = ((64'd64 + $urandom_range(0, 100)) << 12) | 64'd1;
        default: ;
      endcase
      if ($urandom_range(0, 99) < 80) wi = 15'($urandom_range(0, 32767));
      send_item(MODE_RAW, va, pa, fl, wi, w);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 0;
    // default root 0, allocator from 1
    send_item(MODE_TRANSLATE, 48'h0, 52'h0, 12'h0, 15'h0, 64'h0);
    send_item(MODE_UNMAP, 48'hFFFF_FFFF_FFFF, 52'h0, 12'h0, 15'h0, 64'h0);
    send_item(MODE_MAP, 48'h0, 52'hF_FFFF_FFFF_FFFF, 12'hFFF, 15'h0, 64'h0);
    send_item(MODE_TRANSLATE, 48'h0000_0000_0ABC, 52'h0, 12'h0, 15'h0, 64'h0);
    send_item(MODE_MAP, 48'hFFFF_FFFF_FFFF, 52'h0, 12'h000, 15'h0, 64'h0);
    send_item(MODE_TRANSLATE, 48'hFFFF_FFFF_FFFF, 52'h0, 12'h0, 15'h0, 64'h0);
    send_item(MODE_MAP, 48'h0000_0000_1000, 52'h1234_5000, 12'h004, 15'h0, 64'h0);
    send_item(MODE_UNMAP, 48'h0, 52'h0, 12'h0, 15'h0, 64'h0);
    send_item(MODE_TRANSLATE, 48'h0, 52'h0, 12'h0, 15'h0, 64'h0);
    // raw write with the huge bit set: the PT of va 0 lives at frame 3, write its entry index 1
    send_item(MODE_RAW, 48'h0, 52'h0, 12'h0, 15'd1537, 64'hFFF0_0000_0000_0081);
    send_item(MODE_TRANSLATE, 48'h0000_003F_FFFF, 52'h0, 12'h0, 15'h0, 64'h0);
    send_item(MODE_MAP, 48'h0000_0020_0000, 52'hABCDE_F000, 12'h003, 15'h0, 64'h0);
    // pointer to a frame outside the store at the PML4 level
    send_item(MODE_RAW, 48'h0, 52'h0, 12'h0, 15'd5, 64'h0000_0000_0007_F001);
    send_item(MODE_TRANSLATE, 48'h0000_0280_0000_0000, 52'h0, 12'h0, 15'h0, 64'h0);
    send_item(MODE_MAP, 48'h0000_0280_0000_0000, 52'h0, 12'h0, 15'h0, 64'h0);
    send_item(MODE_RAW, 48'h0, 52'h0, 12'h0, 15'h7FFF, 64'hFFFF_FFFF_FFFF_FFFF);
    drain();
    // root at the last frame of the store, then exhaustion with a tight limit
    write_reg(REG_ROOT_FRAME, 7'd63);
    write_reg(REG_ALLOC_BASE, 7'd62);
    write_reg(REG_ALLOC_LIMIT, 7'd63);
    send_item(MODE_MAP, 48'h1234_5678_9000, 52'h1000, 12'h005, 15'h0, 64'h0);
    send_item(MODE_TRANSLATE, 48'h1234_5678_9000, 52'h0, 12'h0, 15'h0, 64'h0);
    drain();
    write_reg(REG_ALLOC_LIMIT, 7'd0);
    send_item(MODE_MAP, 48'h0, 52'h1000, 12'h0, 15'h0, 64'h0);
    drain();
    // random phases under several settings
    for (int ph = 0; ph < 4; ph++) begin
      stall_on = (ph != 2);
      case (ph)
        0: begin
          write_reg(REG_ROOT_FRAME, 7'd0);
          write_reg(REG_ALLOC_BASE, 7'd8);
          write_reg(REG_ALLOC_LIMIT, 7'd64);
        end
        1: begin
          write_reg(REG_ROOT_FRAME, 7'd40);
          write_reg(REG_ALLOC_BASE, 7'd41);
          write_reg(REG_ALLOC_LIMIT, 7'd127);
        end
        2: begin
          write_reg(REG_ROOT_FRAME, 7'd20);
          write_reg(REG_ALLOC_BASE, 7'd0);
          write_reg(REG_ALLOC_LIMIT, 7'd30);
        end
        default: begin
          write_reg(REG_ROOT_FRAME, 7'd1);
          write_reg(REG_ALLOC_BASE, 7'd50);
          write_reg(REG_ALLOC_LIMIT, 7'd64);
        end
      endcase
      va_pool.delete();
      for (int n = 0; n < 100; n++) begin
        random_item();
        if (n == 50) drain();
      end
      drain();
    end
    if (fail_count == 0) begin
      $display("four_level_page_table_engine test passed");
    end else begin
      $display("four_level_page_table_engine test failed");
    end
    $finish;
  end

endmodule

@@ four_level_page_table_engine.f @@
rtl/fptw_pkg.sv
rtl/fptw_ram.sv
rtl/fptw_front.sv
rtl/fptw_walker.sv
rtl/four_level_page_table_engine.sv
test/fptw_checker.sv
test/tb_four_level_page_table_engine.sv
